// ===== hdl/rrp_pkg.sv =====
// Shared operation, status and register codes for the rectangle raster painter.
`default_nettype none

package rrp_pkg;

  // Fixed widths of the command and result fields.
  localparam int unsigned CoordW   = 18;
  localparam int unsigned CharW    = 8;
  localparam int unsigned PixIdxW  = 8;
  localparam int unsigned DimRegW  = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_e;

  localparam logic [CfgIdxW-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BACKGROUND    = 2'd2;

  localparam logic [DimRegW-1:0] CANVAS_WIDTH_RST  = 9'd256;
  localparam logic [DimRegW-1:0] CANVAS_HEIGHT_RST = 9'd256;
  localparam logic [CharW-1:0]   BACKGROUND_RST    = 8'd32;

endpackage

`default_nettype wire

// ===== hdl/rectangle_raster_painter.sv =====
// Top level of the rectangle raster painter: canvas memory, sweep sequencer and result register.
`default_nettype none

// The block keeps a byte canvas in one synchronous memory, pixel (col,row) at
// address {row,col}. A command is accepted on a rising edge with start_i high
// and busy_o low; it carries the operation and every field at once.
// A clear command writes background_char into every in-use pixel, and a draw
// command writes paint_char into the pixels covered by the rectangle (in
// outline mode only those on its border band); both sweep the in-use canvas
// row by row, one pixel per cycle through the single memory write port. A
// rectangle of zero or negative size, an empty canvas, an out-of-range read
// and the unused operation are answered straight from the idle state with no
// sweep. A read in range goes through the memory read, then the result beat.
// Every command yields exactly one result beat: done_o is high for one cycle
// with status_o and pixel_char_o valid. The receiver cannot stall, and a new
// command may be started in the cycle in which the result is shown.
// Configuration writes are taken at any edge with cfg_we_i high and are meant
// for idle periods only. Reset restores the configuration to a 256 by 256
// canvas with a space background; the canvas contents stay undefined until the
// first clear, and no clearing pass runs after reset.
module rectangle_raster_painter
  import rrp_pkg::*;
#(
  parameter int unsigned MAX_DIM   = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // Configuration write port.
  input  wire                        cfg_we_i,
  input  wire  [CfgIdxW-1:0]         cfg_idx_i,
  input  wire  [CfgDataW-1:0]        cfg_wdata_i,
  // Command channel.
  input  wire                        start_i,
  output logic                       busy_o,
  input  wire  [1:0]                 op_i,
  input  wire                        filled_mode_i,
  input  wire  signed [CoordW-1:0]   rect_left_i,
  input  wire  signed [CoordW-1:0]   rect_top_i,
  input  wire  signed [CoordW-1:0]   rect_width_i,
  input  wire  signed [CoordW-1:0]   rect_height_i,
  input  wire  [CharW-1:0]           paint_char_i,
  input  wire  [PixIdxW-1:0]         pixel_col_i,
  input  wire  [PixIdxW-1:0]         pixel_row_i,
  // Result channel.
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [CharW-1:0]           pixel_char_o
);

  // Index width of one canvas axis and width of a count that can hold MAX_DIM.
  localparam int unsigned IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CntW  = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW  = (CntW > PixIdxW) ? CntW : PixIdxW;
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 1 << AddrW;
  // Signed working width for fixed-point coordinates, with headroom for the
  // rectangle's far edge and for a pixel position one beyond the canvas.
  localparam int unsigned PosW  = IdxW + 1 + FRAC_BITS;
  localparam int unsigned CW    = ((PosW > CoordW + 1) ? PosW : CoordW + 1) + 2;
  localparam logic signed [CW-1:0] One = CW'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_READ
  } state_e;

  // Configuration registers.
  logic [DimRegW-1:0] canvas_width_q, canvas_height_q;
  logic [CharW-1:0]   background_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= CANVAS_WIDTH_RST;
      canvas_height_q <= CANVAS_HEIGHT_RST;
      background_q    <= BACKGROUND_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_CANVAS_WIDTH) begin
        canvas_width_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_CANVAS_HEIGHT) begin
        canvas_height_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_BACKGROUND) begin
        background_q <= cfg_wdata_i[CharW-1:0];
      end
    end
  end

  // In-use canvas size: the register values saturated to MAX_DIM.
  logic [CntW-1:0] used_w, used_h;
  assign used_w = (32'(canvas_width_q) > MAX_DIM)  ? CntW'(MAX_DIM) : CntW'(canvas_width_q);
  assign used_h = (32'(canvas_height_q) > MAX_DIM) ? CntW'(MAX_DIM) : CntW'(canvas_height_q);

  state_e            state_q;
  logic              done_q;
  status_e           status_q;
  logic [CharW-1:0]  pix_q;
  logic [IdxW-1:0]   col_q, row_q;
  op_e               op_q;

  // Rectangle geometry held for the sweep: the near edges, the near edges plus
  // one pixel pitch (the inner bound of the outline band) and the far edges.
  logic signed [CW-1:0] left_q, left1_q, right_q, top_q, top1_q, bottom_q;
  logic                 filled_q;
  logic [CharW-1:0]     wdata_q;

  logic accept;
  op_e  op_in;
  logic bad_size, canvas_empty, read_inside;
  logic [CmpW-1:0] rd_col, rd_row;

  assign accept       = start_i && (state_q == S_IDLE);
  assign op_in        = op_e'(op_i);
  assign bad_size     = (rect_width_i <= 0) || (rect_height_i <= 0);
  assign canvas_empty = (used_w == '0) || (used_h == '0);
  assign rd_col       = CmpW'(pixel_col_i);
  assign rd_row       = CmpW'(pixel_row_i);
  assign read_inside  = (rd_col < CmpW'(used_w)) && (rd_row < CmpW'(used_h));

  // Pixel coverage test for the current sweep position. The far-edge band
  // test right - x < 1 is done as x + 1 > right.
  logic [IdxW:0]        col_inc, row_inc;
  logic signed [CW-1:0] px, px1, py, py1;
  logic                 in_rect, on_edge, col_last, row_last;

  assign col_inc  = (IdxW + 1)'(col_q) + 1'b1;
  assign row_inc  = (IdxW + 1)'(row_q) + 1'b1;
  assign px       = CW'({col_q, FRAC_BITS'(0)});
  assign px1      = CW'({col_inc, FRAC_BITS'(0)});
  assign py       = CW'({row_q, FRAC_BITS'(0)});
  assign py1      = CW'({row_inc, FRAC_BITS'(0)});
  assign in_rect  = (px >= left_q) && (px <= right_q) && (py >= top_q) && (py <= bottom_q);
  assign on_edge  = (px < left1_q) || (px1 > right_q) || (py < top1_q) || (py1 > bottom_q);
  assign col_last = (CntW'(col_q) == used_w - 1'b1);
  assign row_last = (CntW'(row_q) == used_h - 1'b1);

  // Memory port controls.
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [CharW-1:0] mem_rdata_q;

  assign mem_we    = (state_q == S_SWEEP) &&
                     ((op_q == OP_CLEAR) || (in_rect && (on_edge || filled_q)));
  assign mem_waddr = {row_q, col_q};
  assign mem_re    = accept && (op_in == OP_READ) && read_inside;
  assign mem_raddr = {rd_row[IdxW-1:0], rd_col[IdxW-1:0]};

  logic [CharW-1:0] canvas_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_mem[mem_waddr] <= wdata_q;
    end
    if (mem_re) begin
      mem_rdata_q <= canvas_mem[mem_raddr];
    end
  end

  // Command payload captured on acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_in;
      filled_q <= filled_mode_i;
      wdata_q  <= (op_in == OP_CLEAR) ? background_q : paint_char_i;
      left_q   <= CW'(rect_left_i);
      left1_q  <= CW'(rect_left_i) + One;
      right_q  <= CW'(rect_left_i) + CW'(rect_width_i);
      top_q    <= CW'(rect_top_i);
      top1_q   <= CW'(rect_top_i) + One;
      bottom_q <= CW'(rect_top_i) + CW'(rect_height_i);
    end
  end

  // Sequencer with the registered result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      pix_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            col_q <= '0;
            row_q <= '0;
            pix_q <= '0;
            unique case (op_in)
              OP_DRAW: begin
                if (bad_size) begin
                  done_q   <= 1'b1;
                  status_q <= ST_BAD_SIZE;
                end else if (canvas_empty) begin
                  done_q   <= 1'b1;
                  status_q <= ST_OK;
                end else begin
                  state_q <= S_SWEEP;
                end
              end
              OP_CLEAR: begin
                if (canvas_empty) begin
                  done_q   <= 1'b1;
                  status_q <= ST_OK;
                end else begin
                  state_q <= S_SWEEP;
                end
              end
              OP_READ: begin
                if (read_inside) begin
                  state_q <= S_READ;
                end else begin
                  done_q   <= 1'b1;
                  status_q <= ST_OUTSIDE;
                end
              end
              OP_NONE: begin
                done_q   <= 1'b1;
                status_q <= ST_OK;
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= ST_OK;
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (col_last) begin
            col_q <= '0;
            if (row_last) begin
              state_q  <= S_IDLE;
              done_q   <= 1'b1;
              status_q <= ST_OK;
            end else begin
              row_q <= row_inc[IdxW-1:0];
            end
          end else begin
            col_q <= col_inc[IdxW-1:0];
          end
        end
        S_READ: begin
          state_q  <= S_IDLE;
          done_q   <= 1'b1;
          status_q <= ST_OK;
          pix_q    <= mem_rdata_q;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign pixel_char_o = pix_q;

  // The sweep never writes outside the in-use canvas.
  a_write_in_canvas : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((CntW'(col_q) < used_w) && (CntW'(row_q) < used_h)))
    else $error("canvas write outside the in-use area");

  // Every return to idle from a multi-cycle command comes with its result beat.
  a_done_on_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("command finished without a result beat");

  // A rectangle of non-positive size is rejected in the next cycle.
  a_bad_size_reply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_in == OP_DRAW) && bad_size) |=> (done_o && (status_o == ST_BAD_SIZE)))
    else $error("non-positive rectangle not rejected");

  // A result beat carries canvas data only when it answers a successful read.
  a_pix_only_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (pixel_char_o != '0)) |-> ((status_o == ST_OK) && $past(state_q == S_READ)))
    else $error("pixel byte shown outside a read result");

endmodule

`default_nettype wire

// ===== sim/rectangle_raster_painter_checker.sv =====
// Checker for the rectangle raster painter: keeps a canvas model and compares every result beat.
module rectangle_raster_painter_checker
  import rrp_pkg::*;
#(
  parameter int unsigned MAX_DIM   = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                op_i,
  input  logic                      filled_mode_i,
  input  logic signed [CoordW-1:0]  rect_left_i,
  input  logic signed [CoordW-1:0]  rect_top_i,
  input  logic signed [CoordW-1:0]  rect_width_i,
  input  logic signed [CoordW-1:0]  rect_height_i,
  input  logic [CharW-1:0]          paint_char_i,
  input  logic [PixIdxW-1:0]        pixel_col_i,
  input  logic [PixIdxW-1:0]        pixel_row_i,
  input  logic                      done_i,
  input  logic [1:0]                status_i,
  input  logic [CharW-1:0]          pixel_char_i,
  output int                        outstanding_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int One = 1 << FRAC_BITS;

  typedef struct packed {
    status_e          status;
    logic [CharW-1:0] pixel_char;
  } answer_t;

  answer_t          answer_q[$];
  logic [CharW-1:0] canvas_model [MAX_DIM*MAX_DIM];
  logic [DimRegW-1:0] width_reg      = CANVAS_WIDTH_RST;
  logic [DimRegW-1:0] height_reg     = CANVAS_HEIGHT_RST;
  logic [CharW-1:0]   background_reg = BACKGROUND_RST;
  answer_t            oldest;

  initial begin
    outstanding_o = 0;
    fail_count_o  = 0;
  end

  // Register values above the canvas size saturate to it.
  function automatic int used_dim(logic [DimRegW-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  // Applies one command to the canvas model and returns its answer.
  function automatic answer_t paint_canvas(
    logic [1:0] op, logic filled, int left, int top, int wd, int ht,
    logic [CharW-1:0] paint, logic [PixIdxW-1:0] col, logic [PixIdxW-1:0] row
  );
    int      cols;
    int      rows;
    int      right;
    int      bottom;
    int      px;
    int      py;
    bit      on_border;
    answer_t ans;
    cols   = used_dim(width_reg);
    rows   = used_dim(height_reg);
    right  = left + wd;
    bottom = top + ht;
    ans.status     = ST_OK;
    ans.pixel_char = '0;
    case (op_e'(op))
      OP_DRAW: begin
        if (wd <= 0 || ht <= 0) begin
          ans.status = ST_BAD_SIZE;
        end else begin
          for (int r = 0; r < rows; r++) begin
            py = r * One;
            if (py < top || py > bottom) continue;
            for (int c = 0; c < cols; c++) begin
              px = c * One;
              if (px < left || px > right) continue;
              on_border = (px - left < One) || (right - px < One) ||
                          (py - top < One) || (bottom - py < One);
              if (on_border || filled) canvas_model[r * MAX_DIM + c] = paint;
            end
          end
        end
      end
      OP_CLEAR: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++) canvas_model[r * MAX_DIM + c] = background_reg;
      end
      OP_READ: begin
        if (int'(col) >= cols || int'(row) >= rows) ans.status = ST_OUTSIDE;
        else ans.pixel_char = canvas_model[int'(row) * MAX_DIM + int'(col)];
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg      = CANVAS_WIDTH_RST;
      height_reg     = CANVAS_HEIGHT_RST;
      background_reg = BACKGROUND_RST;
      answer_q.delete();
    end else begin
      // A result beat leaving belongs to an older command than one entering
      // at the same edge, so it is compared first.
      if (done_i === 1'b1) begin
        if (answer_q.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result beat with nothing expected, status %0d char 0x%02h",
                   $time, status_i, pixel_char_i);
        end else begin
          oldest = answer_q.pop_front();
          if (status_i !== oldest.status) begin
            fail_count_o++;
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, oldest.status, status_i);
          end
          if (pixel_char_i !== oldest.pixel_char) begin
            fail_count_o++;
            $display("%0t ns: pixel_char mismatch, expected 0x%02h, actual 0x%02h",
                     $time, oldest.pixel_char, pixel_char_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        answer_q.push_back(paint_canvas(op_i, filled_mode_i, int'(rect_left_i),
                                        int'(rect_top_i), int'(rect_width_i),
                                        int'(rect_height_i), paint_char_i,
                                        pixel_col_i, pixel_row_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CANVAS_WIDTH:  width_reg      = cfg_wdata_i;
          REG_CANVAS_HEIGHT: height_reg     = cfg_wdata_i;
          REG_BACKGROUND:    background_reg = cfg_wdata_i[CharW-1:0];
          default: ;
        endcase
      end
    end
    outstanding_o = answer_q.size();
  end

endmodule

// ===== sim/rectangle_raster_painter_test.sv =====
// Stimulus and verdict for the rectangle raster painter, with the checker beside the block.
module rectangle_raster_painter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rrp_pkg::*;

  // Sender gap chances per random phase, in a hundred. The third phase is the
  // one in which the receiver would stall; it cannot hold results off, so
  // that phase runs as a further stretch with no idling at all.
  localparam int IdlePct [4]     = '{0, 64, 0, 35};
  localparam int ItemsPerSetting = 6;
  localparam int SettingsPerPhase = 3;
  // A full 256 by 256 sweep runs with no beat moving; the watchdog limit
  // leaves room for several of those back to back before it gives up.
  localparam int StallLimit      = 300000;
  localparam int DrainCycles     = 20;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam logic [CharW-1:0]   CharUpperR = 8'h52;
  localparam logic [CharW-1:0]   CharLowerR = 8'h72;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we        = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx       = '0;
  logic [CfgDataW-1:0]       cfg_wdata     = '0;
  logic                      start         = 1'b0;
  logic [1:0]                op            = '0;
  logic                      filled_mode   = 1'b0;
  logic signed [CoordW-1:0]  rect_left     = '0;
  logic signed [CoordW-1:0]  rect_top      = '0;
  logic signed [CoordW-1:0]  rect_width    = '0;
  logic signed [CoordW-1:0]  rect_height   = '0;
  logic [CharW-1:0]          paint_char    = '0;
  logic [PixIdxW-1:0]        pixel_col     = '0;
  logic [PixIdxW-1:0]        pixel_row     = '0;
  logic                      busy;
  logic                      done;
  logic [1:0]                status;
  logic [CharW-1:0]          pixel_char;
  int                        outstanding;
  int                        failures;

  // What the stimulus believes the registers hold, used to aim rectangles
  // and reads at the canvas in use.
  logic [DimRegW-1:0] cur_width  = CANVAS_WIDTH_RST;
  logic [DimRegW-1:0] cur_height = CANVAS_HEIGHT_RST;
  int idle_pct     = 0;
  int draws_sent   = 0;
  int clears_sent  = 0;
  int reads_sent   = 0;
  int others_sent  = 0;
  int settings_run = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rectangle_raster_painter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .start_i       (start),
    .busy_o        (busy),
    .op_i          (op),
    .filled_mode_i (filled_mode),
    .rect_left_i   (rect_left),
    .rect_top_i    (rect_top),
    .rect_width_i  (rect_width),
    .rect_height_i (rect_height),
    .paint_char_i  (paint_char),
    .pixel_col_i   (pixel_col),
    .pixel_row_i   (pixel_row),
    .done_o        (done),
    .status_o      (status),
    .pixel_char_o  (pixel_char)
  );

  rectangle_raster_painter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .start_i       (start),
    .busy_i        (busy),
    .op_i          (op),
    .filled_mode_i (filled_mode),
    .rect_left_i   (rect_left),
    .rect_top_i    (rect_top),
    .rect_width_i  (rect_width),
    .rect_height_i (rect_height),
    .paint_char_i  (paint_char),
    .pixel_col_i   (pixel_col),
    .pixel_row_i   (pixel_row),
    .done_i        (done),
    .status_i      (status),
    .pixel_char_i  (pixel_char),
    .outstanding_o (outstanding),
    .fail_count_o  (failures)
  );

  // Saturated canvas sizes, as the block sees them.
  function automatic int used_cols();
    return (int'(cur_width) > 256) ? 256 : int'(cur_width);
  endfunction

  function automatic int used_rows();
    return (int'(cur_height) > 256) ? 256 : int'(cur_height);
  endfunction

  // A corner coordinate from two pixels before the canvas to two after it,
  // snapped to a whole pixel about a third of the time so that edges land
  // exactly on pixel centres.
  function automatic logic [CoordW-1:0] near_coord(int dim);
    int v;
    v = int'($urandom_range(0, (dim + 4) * 256)) - 2 * 256;
    if ($urandom_range(2) == 0) v = v & ~32'hFF;
    return CoordW'(v);
  endfunction

  // A positive extent reaching up to two pixels past the canvas.
  function automatic logic [CoordW-1:0] extent(int dim);
    int v;
    v = int'($urandom_range(1, (dim + 2) * 256));
    if ($urandom_range(2) == 0 && v > 256) v = v & ~32'hFF;
    return CoordW'(v);
  endfunction

  // Presents one command beat from a falling edge and holds it until the
  // block takes it. Returns at the falling edge after acceptance with start
  // still high, so a following beat can go out with no gap.
  task automatic send_command(
    input logic [1:0] o, input logic fm,
    input logic [CoordW-1:0] l, input logic [CoordW-1:0] t,
    input logic [CoordW-1:0] wd, input logic [CoordW-1:0] ht,
    input logic [CharW-1:0] pc, input logic [PixIdxW-1:0] cc, input logic [PixIdxW-1:0] rr
  );
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op          <= o;
    filled_mode <= fm;
    rect_left   <= l;
    rect_top    <= t;
    rect_width  <= wd;
    rect_height <= ht;
    paint_char  <= pc;
    pixel_col   <= cc;
    pixel_row   <= rr;
    start       <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (op_e'(o))
      OP_DRAW:  draws_sent++;
      OP_CLEAR: clears_sent++;
      OP_READ:  reads_sent++;
      default:  others_sent++;
    endcase
    @(negedge clk_i);
  endtask

  // The helpers below fill the fields that the operation ignores with noise.
  task automatic draw_rect(
    input logic fm, input logic [CoordW-1:0] l, input logic [CoordW-1:0] t,
    input logic [CoordW-1:0] wd, input logic [CoordW-1:0] ht, input logic [CharW-1:0] pc
  );
    send_command(OP_DRAW, fm, l, t, wd, ht, pc, PixIdxW'($urandom), PixIdxW'($urandom));
  endtask

  task automatic clear_canvas();
    send_command(OP_CLEAR, 1'($urandom), CoordW'($urandom), CoordW'($urandom),
                 CoordW'($urandom), CoordW'($urandom), CharW'($urandom),
                 PixIdxW'($urandom), PixIdxW'($urandom));
  endtask

  task automatic read_pixel(input logic [PixIdxW-1:0] cc, input logic [PixIdxW-1:0] rr);
    send_command(OP_READ, 1'($urandom), CoordW'($urandom), CoordW'($urandom),
                 CoordW'($urandom), CoordW'($urandom), CharW'($urandom), cc, rr);
  endtask

  // Registers are only written once the block has answered everything.
  // Every command gives one result, so an empty queue means the block is idle.
  task automatic configure(
    input logic [DimRegW-1:0] w, input logic [DimRegW-1:0] h,
    input logic [CharW-1:0] bg, input bit poke_unused
  );
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_CANVAS_WIDTH;
    cfg_wdata <= w;
    @(negedge clk_i);
    cfg_idx   <= REG_CANVAS_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk_i);
    // The spare top bit of the data word is noise for the background byte.
    cfg_idx   <= REG_BACKGROUND;
    cfg_wdata <= {1'($urandom), bg};
    @(negedge clk_i);
    if (poke_unused) begin
      cfg_idx   <= RegUnused;
      cfg_wdata <= CfgDataW'($urandom);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    cur_width  = w;
    cur_height = h;
    settings_run++;
  endtask

  // Watchdog: ends the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Watchdog: no beat for %0d cycles at %0t ns", StallLimit, $time);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int cols;
    int rows;
    int pick;
    int kind;
    logic [CoordW-1:0] l;
    logic [CoordW-1:0] t;
    logic [CoordW-1:0] wd;
    logic [CoordW-1:0] ht;
    logic [DimRegW-1:0] new_w;
    logic [DimRegW-1:0] new_h;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset setting of 256 by 256 with a space
    // background. The canvas is undefined after reset, so the first thing done
    // is a full clear; from then on every pixel of the store holds a value.
    clear_canvas();
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
    // Outline of the whole canvas: the border row and column get painted,
    // the interior keeps the background.
    draw_rect(1'b0, '0, '0, CoordW'(255 * 256), CoordW'(255 * 256), CharUpperR);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd128, 8'd128);
    read_pixel(8'd255, 8'd128);
    read_pixel(8'd200, 8'd255);
    // The unused operation with every field at all ones.
    send_command(OP_NONE, 1'b1, '1, '1, '1, '1, '1, '1, '1);
    // Sizes of zero, minus one step and the most negative value are rejected
    // and must not touch the canvas.
    draw_rect(1'b1, CoordW'(256), CoordW'(256), '0, CoordW'(256), 8'hFF);
    draw_rect(1'b0, '0, '0, CoordW'(256), CoordW'(-1), 8'h00);
    draw_rect(1'b1, '0, '0, CoordW'(-131072), CoordW'(256), 8'hFF);
    read_pixel(8'd1, 8'd1);

    // Empty canvas: width zero with an oversized height register. Clear and
    // draw touch nothing and every read falls outside.
    configure(9'd0, 9'd511, 8'hFF, 1'b1);
    clear_canvas();
    read_pixel(8'd0, 8'd0);
    draw_rect(1'b1, '0, '0, CoordW'(256), CoordW'(256), 8'h5A);

    // A single pixel canvas with a zero background.
    configure(9'd1, 9'd1, 8'h00, 1'b0);
    clear_canvas();
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd1, 8'd0);
    read_pixel(8'd255, 8'd255);
    // Most negative corner with the largest size ends just short of zero.
    draw_rect(1'b1, CoordW'(-131072), CoordW'(-131072), CoordW'(131071), CoordW'(131071),
              CharLowerR);
    read_pixel(8'd0, 8'd0);
    // Half-pixel offsets: the rectangle straddles the only pixel centre.
    draw_rect(1'b1, CoordW'(-128), CoordW'(-128), CoordW'(256), CoordW'(256), CharLowerR);
    read_pixel(8'd0, 8'd0);

    // Random part. Each phase runs through several canvas settings, mostly
    // small so that sweeps stay short; a few stretch one side to between 200
    // and 511 while the other stays tiny, and some are empty.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = IdlePct[phase];
      for (int setting = 0; setting < SettingsPerPhase; setting++) begin
        kind = $urandom_range(9);
        if (kind < 6) begin
          new_w = DimRegW'($urandom_range(1, 24));
          new_h = DimRegW'($urandom_range(1, 24));
        end else if (kind == 6) begin
          new_w = DimRegW'($urandom_range(256, 511));
          new_h = DimRegW'($urandom_range(1, 3));
        end else if (kind == 7) begin
          new_w = DimRegW'($urandom_range(1, 3));
          new_h = DimRegW'($urandom_range(256, 511));
        end else if (kind == 8) begin
          new_w = DimRegW'($urandom_range(200, 255));
          new_h = 9'd1;
        end else begin
          new_w = $urandom_range(1) ? 9'd0 : DimRegW'($urandom_range(1, 8));
          new_h = (new_w == 9'd0) ? DimRegW'($urandom_range(1, 8)) : 9'd0;
        end
        configure(new_w, new_h, CharW'($urandom), $urandom_range(3) == 0);
        cols = used_cols();
        rows = used_rows();

        repeat (ItemsPerSetting) begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            // Mostly rectangles aimed at the canvas; the rest are raw noise
            // over the whole field range or deliberately nonpositive sizes.
            l    = near_coord(cols);
            t    = near_coord(rows);
            wd   = extent(cols);
            ht   = extent(rows);
            kind = $urandom_range(99);
            if (kind < 15) begin
              l  = CoordW'($urandom);
              t  = CoordW'($urandom);
              wd = CoordW'($urandom);
              ht = CoordW'($urandom);
            end else if (kind < 25) begin
              if ($urandom_range(1)) wd = CoordW'(0 - int'($urandom_range(0, 4096)));
              else ht = CoordW'(0 - int'($urandom_range(0, 4096)));
            end
            draw_rect(1'($urandom), l, t, wd, ht, CharW'($urandom));
          end else if (pick < 52) begin
            clear_canvas();
          end else if (pick < 92) begin
            if (cols > 0 && rows > 0 && $urandom_range(9) < 8)
              read_pixel(PixIdxW'($urandom_range(0, cols - 1)),
                         PixIdxW'($urandom_range(0, rows - 1)));
            else
              read_pixel(PixIdxW'($urandom), PixIdxW'($urandom));
          end else begin
            send_command(OP_NONE, 1'($urandom), CoordW'($urandom), CoordW'($urandom),
                         CoordW'($urandom), CoordW'($urandom), CharW'($urandom),
                         PixIdxW'($urandom), PixIdxW'($urandom));
          end
        end
      end
    end

    // Let every outstanding result arrive, then watch a little longer for
    // stray beats before the verdict.
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d draws, %0d clears, %0d pixel reads and %0d unused-op commands",
             draws_sent, clears_sent, reads_sent, others_sent);
    $display("over %0d canvas settings, with sender gaps of none, 35 and 64 in a hundred.",
             settings_run);
    if (failures == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
